@@ hw/rtl/pfs_pkg.sv @@
// Package for the printf format scanner: item types, character codes,
// result kinds and scanner phases. No dependencies.
package pfs_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CH_W            = 8;
  localparam int KIND_W          = 3;
  localparam int EST_OUT_W       = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CH_W-1:0] CHR_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CHR_PCT   = 8'h25;
  localparam logic [CH_W-1:0] CHR_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CHR_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CHR_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CHR_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CHR_ELL   = 8'h6C;
  localparam logic [CH_W-1:0] CHR_C     = 8'h63;
  localparam logic [CH_W-1:0] CHR_D     = 8'h64;
  localparam logic [CH_W-1:0] CHR_E     = 8'h65;
  localparam logic [CH_W-1:0] CHR_F     = 8'h66;
  localparam logic [CH_W-1:0] CHR_G     = 8'h67;
  localparam logic [CH_W-1:0] CHR_O     = 8'h6F;
  localparam logic [CH_W-1:0] CHR_S     = 8'h73;
  localparam logic [CH_W-1:0] CHR_X     = 8'h78;

  typedef enum logic [KIND_W-1:0] {
    KIND_INT = 3'd0,
    KIND_NUM = 3'd1,
    KIND_STR = 3'd2,
    KIND_END = 3'd3,
    KIND_BAD = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_NUL,
    CLS_PCT,
    CLS_MINUS,
    CLS_DOT,
    CLS_ELL,
    CLS_DIGIT
  } cls_t;

  typedef enum logic [2:0] {
    PH_LIT   = 3'd0,
    PH_PCT   = 3'd1,
    PH_MINUS = 3'd2,
    PH_WID   = 3'd3,
    PH_DOT   = 3'd4,
    PH_PREC  = 3'd5,
    PH_LONG  = 3'd6
  } phase_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            start;
    cls_t            cls;
    logic [3:0]      digit;
    kind_t           kind;
  } rec_t;

endpackage

@@ hw/rtl/pfs_if.sv @@
// Channel interfaces of the printf format scanner: input items and results.
// Depends on pfs_pkg for field widths.
interface pfs_in_if import pfs_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            start_req;

  modport source (output valid, output ch, output start_req, input ready);
  modport sink   (input valid, input ch, input start_req, output ready);
endinterface

interface pfs_out_if import pfs_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [EST_OUT_W-1:0] size_estimate;
  logic [CH_W-1:0]      bad_char;
  logic                 last;

  modport source (output valid, output kind, output size_estimate, output bad_char,
                  output last, input ready);
  modport sink   (input valid, input kind, input size_estimate, input bad_char,
                  input last, output ready);
endinterface

@@ hw/rtl/printf_format_scanner_unit.sv @@
// Top level of the printf format scanner: front end, item queue, back end.
// Depends on pfs_pkg, pfs_if, pfs_front, pfs_queue and pfs_back.
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+------------------------------------
//   in_if    | in  | valid/ready         | ch, start_req
//   out_if   | out | valid/ready         | kind, size_estimate, bad_char, last
//
// One character per cycle while the queue is not full; an accepted character
// passes the queue and then the result register. A NUL inside a specifier
// gives two results and holds the back end on the single result register.
// in_if.ready follows the two-entry queue occupancy, so output stalls reach
// the input only once the queue is full; characters without a result drain
// while the result register waits.
// Reset is synchronous and clears phase, estimate and number.
module printf_format_scanner_unit import pfs_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pfs_in_if.sink    in_if,
  pfs_out_if.source out_if
);

  logic q_full;
  logic q_valid;
  logic push;
  logic pop;
  rec_t push_rec;
  rec_t head_rec;

  pfs_front u_front (
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_full (q_full),
    .push   (push),
    .rec    (push_rec)
  );

  pfs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_rec),
    .pop       (pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (head_rec)
  );

  pfs_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .rec     (head_rec),
    .q_pop   (pop),
    .out_if  (out_if)
  );

endmodule

@@ hw/rtl/pfs_front.sv @@
// Front end: accepts input items and classifies each character.
// Depends on pfs_pkg and pfs_in_if.
module pfs_front import pfs_pkg::*; (
  input  logic     rst_n,
  pfs_in_if.sink   in_if,
  input  logic     q_full,
  output logic     push,
  output rec_t     rec
);

  cls_t  cls;
  kind_t kind;

  assign in_if.ready = rst_n && !q_full;
  assign push        = in_if.valid && in_if.ready;

  always_comb begin
    unique case (in_if.ch)
      CHR_NUL:   cls = CLS_NUL;
      CHR_PCT:   cls = CLS_PCT;
      CHR_MINUS: cls = CLS_MINUS;
      CHR_DOT:   cls = CLS_DOT;
      CHR_ELL:   cls = CLS_ELL;
      default: begin
        if (in_if.ch >= CHR_ZERO && in_if.ch <= CHR_NINE) cls = CLS_DIGIT;
        else cls = CLS_OTHER;
      end
    endcase
  end

  always_comb begin
    unique case (in_if.ch) inside
      CHR_C, CHR_D, CHR_O, CHR_X: kind = KIND_INT;
      CHR_E, CHR_F, CHR_G:        kind = KIND_NUM;
      CHR_S:                      kind = KIND_STR;
      default:                    kind = KIND_BAD;
    endcase
  end

  always_comb begin
    rec.ch    = in_if.ch;
    rec.start = in_if.start_req;
    rec.cls   = cls;
    rec.digit = 4'(in_if.ch - CHR_ZERO);
    rec.kind  = kind;
  end

endmodule

@@ hw/rtl/pfs_queue.sv @@
// Short queue of classified items between front and back end.
// Depends on pfs_pkg.
module pfs_queue import pfs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_data,
  input  logic pop,
  output logic full,
  output logic valid,
  output rec_t head
);

  rec_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/pfs_back.sv @@
// Back end: scan phase, running estimate, number accumulation and the result
// register. Depends on pfs_pkg and pfs_out_if.
module pfs_back import pfs_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  rec_t      rec,
  output logic      q_pop,
  pfs_out_if.source out_if
);

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                     input logic [COUNT_WIDTH-1:0] b);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_mac10(input logic [COUNT_WIDTH-1:0] v,
                                                       input logic [3:0] d);
    logic [COUNT_WIDTH+3:0] w;
    w = ({4'b0, v} << 3) + ({4'b0, v} << 1) + (COUNT_WIDTH + 4)'(d);
    return (|w[COUNT_WIDTH+3:COUNT_WIDTH]) ? '1 : w[COUNT_WIDTH-1:0];
  endfunction

  phase_t                 phase_r, phase_nxt, phase_e;
  logic [COUNT_WIDTH-1:0] est_r, est_nxt, est_e;
  logic [COUNT_WIDTH-1:0] dv_r, dv_nxt, dv_e;
  logic [COUNT_WIDTH-1:0] est_mid, est_inc_e, est_inc_mid, dv_acc;
  logic                   pend_end_r, pend_end_nxt;

  logic                   tail, conv, flush, acc, load;
  logic                   emit, emit_last, pend_set;
  kind_t                  emit_kind;
  logic [CH_W-1:0]        emit_bad;
  logic [COUNT_WIDTH-1:0] emit_est;
  logic                   out_free, take, end_go;

  logic                   out_valid_r, out_valid_nxt;
  kind_t                  out_kind_r;
  logic [EST_OUT_W-1:0]   out_est_r;
  logic [CH_W-1:0]        out_bad_r;
  logic                   out_last_r;

  // start of a new string clears state before the character is handled
  assign phase_e = rec.start ? PH_LIT : phase_r;
  assign est_e   = rec.start ? '0 : est_r;
  assign dv_e    = rec.start ? '0 : dv_r;

  assign est_mid     = sat_add(est_e, dv_e);
  assign est_inc_e   = sat_add(est_e, COUNT_WIDTH'(1));
  assign est_inc_mid = sat_add(est_mid, COUNT_WIDTH'(1));
  assign dv_acc      = sat_mac10(dv_e, rec.digit);

  // next phase
  always_comb begin
    tail      = 1'b0;
    conv      = 1'b0;
    phase_nxt = phase_e;
    unique case (phase_e) inside
      PH_LIT: begin
        if (rec.cls == CLS_PCT) phase_nxt = PH_PCT;
      end
      PH_PCT, PH_MINUS: begin
        if (phase_e == PH_PCT && rec.cls == CLS_PCT) phase_nxt = PH_LIT;
        else if (phase_e == PH_PCT && rec.cls == CLS_MINUS) phase_nxt = PH_MINUS;
        else if (rec.cls == CLS_DIGIT) phase_nxt = PH_WID;
        else tail = 1'b1;
      end
      PH_WID: begin
        if (rec.cls != CLS_DIGIT) tail = 1'b1;
      end
      PH_DOT: begin
        if (rec.cls == CLS_DIGIT) phase_nxt = PH_PREC;
        else if (rec.cls == CLS_ELL) phase_nxt = PH_LONG;
        else conv = 1'b1;
      end
      PH_PREC: begin
        if (rec.cls == CLS_ELL) phase_nxt = PH_LONG;
        else if (rec.cls != CLS_DIGIT) conv = 1'b1;
      end
      PH_LONG: conv = 1'b1;
      default: phase_nxt = PH_LIT;
    endcase
    if (tail) begin
      if (rec.cls == CLS_DOT) phase_nxt = PH_DOT;
      else if (rec.cls == CLS_ELL) phase_nxt = PH_LONG;
      else conv = 1'b1;
    end
    if (conv) phase_nxt = PH_LIT;
  end

  assign acc   = (phase_e == PH_WID || phase_e == PH_PREC) && rec.cls == CLS_DIGIT;
  assign load  = (phase_e == PH_PCT || phase_e == PH_MINUS || phase_e == PH_DOT) &&
                 rec.cls == CLS_DIGIT;
  assign flush = tail || conv || (phase_e == PH_PREC && rec.cls != CLS_DIGIT);

  // datapath and result
  always_comb begin
    est_nxt   = est_e;
    dv_nxt    = dv_e;
    emit      = 1'b0;
    emit_kind = KIND_END;
    emit_bad  = '0;
    emit_est  = est_e;
    emit_last = 1'b1;
    pend_set  = 1'b0;
    if (phase_e == PH_LIT) begin
      if (rec.cls == CLS_NUL) emit = 1'b1;
      else if (rec.cls != CLS_PCT) est_nxt = est_inc_e;
    end else if (phase_e == PH_PCT && rec.cls == CLS_PCT) begin
      est_nxt = est_inc_e;
    end else if (acc) begin
      dv_nxt = dv_acc;
    end else if (load) begin
      dv_nxt = COUNT_WIDTH'(rec.digit);
    end else if (flush) begin
      est_nxt = est_mid;
      dv_nxt  = '0;
      if (conv) begin
        emit      = 1'b1;
        emit_kind = rec.kind;
        emit_bad  = (rec.kind == KIND_BAD) ? rec.ch : '0;
        emit_est  = est_mid;
        if (rec.cls == CLS_NUL) begin
          emit_last = 1'b0;
          pend_set  = 1'b1;
        end else begin
          est_nxt = est_inc_mid;
        end
      end
    end
  end

  assign out_free = !out_valid_r || out_if.ready;
  assign end_go   = pend_end_r && out_free;
  assign take     = q_valid && !pend_end_r && (out_free || !emit);
  assign q_pop    = take;

  always_comb begin
    pend_end_nxt = pend_end_r;
    if (end_go) pend_end_nxt = 1'b0;
    else if (take && pend_set) pend_end_nxt = 1'b1;
    out_valid_nxt = out_valid_r;
    if (end_go || (take && emit)) out_valid_nxt = 1'b1;
    else if (out_if.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LIT;
      est_r       <= '0;
      dv_r        <= '0;
      pend_end_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt;
        est_r   <= est_nxt;
        dv_r    <= dv_nxt;
      end
      pend_end_r  <= pend_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (end_go) begin
      out_kind_r <= KIND_END;
      out_est_r  <= EST_OUT_W'(est_r);
      out_bad_r  <= '0;
      out_last_r <= 1'b1;
    end else if (take && emit) begin
      out_kind_r <= emit_kind;
      out_est_r  <= EST_OUT_W'(emit_est);
      out_bad_r  <= emit_bad;
      out_last_r <= emit_last;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.kind          = out_kind_r;
  assign out_if.size_estimate = out_est_r;
  assign out_if.bad_char      = out_bad_r;
  assign out_if.last          = out_last_r;

endmodule

@@ hw/rtl/pfs_checker.sv @@
// Port-level checks on the result channel of the printf format scanner,
// bound to printf_format_scanner_unit. Depends on pfs_pkg.
module pfs_checker import pfs_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [KIND_W-1:0]    out_kind,
  input logic [EST_OUT_W-1:0] out_size_estimate,
  input logic [CH_W-1:0]      out_bad_char,
  input logic                 out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_size_estimate) && $stable(out_bad_char) && $stable(out_last))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_END |-> out_last)
    else $error("end result not marked last");

  a_first_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_kind == KIND_BAD && out_bad_char == '0)
    else $error("non-last result is not an illegal NUL");

  a_then_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_kind == KIND_END)
    else $error("end result does not follow illegal NUL");

endmodule

bind printf_format_scanner_unit pfs_checker u_pfs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_kind          (out_if.kind),
  .out_size_estimate (out_if.size_estimate),
  .out_bad_char      (out_if.bad_char),
  .out_last          (out_if.last)
);
